[design/smtpse_pkg.sv]
// ----------------------------------------------------------------------------
// SMTP session engine package
// Shared types and code points for the front classifier, the event queue and
// the session sequencer.
// ----------------------------------------------------------------------------
package smtpse_pkg;

	// Input request kinds, as carried on the slave-side tuser.
	localparam logic [2:0] KIND_SEND     = 3'd0;
	localparam logic [2:0] KIND_CONN     = 3'd1;
	localparam logic [2:0] KIND_ENC      = 3'd2;
	localparam logic [2:0] KIND_BYTE     = 3'd3;
	localparam logic [2:0] KIND_TICK     = 3'd4;
	localparam logic [2:0] KIND_SOCK_ERR = 3'd5;
	localparam logic [2:0] KIND_NONE     = 3'd6;

	// Configuration register indexes.
	localparam logic [2:0] CFG_SECURITY_MODE = 3'd0;
	localparam logic [2:0] CFG_AUTH_ENABLED  = 3'd1;
	localparam logic [2:0] CFG_HOST          = 3'd2;
	localparam logic [2:0] CFG_SERVER_PORT   = 3'd3;
	localparam logic [2:0] CFG_TIMEOUT       = 3'd4;

	localparam logic [1:0] SEC_STARTTLS = 2'd1;
	localparam logic [1:0] SEC_IMPLICIT = 2'd2;

	// Actions.
	localparam logic [3:0] ACT_NONE          = 4'd0;
	localparam logic [3:0] ACT_CONNECT_PLAIN = 4'd1;
	localparam logic [3:0] ACT_CONNECT_TLS   = 4'd2;
	localparam logic [3:0] ACT_EHLO          = 4'd3;
	localparam logic [3:0] ACT_STARTTLS      = 4'd4;
	localparam logic [3:0] ACT_START_TLS     = 4'd5;
	localparam logic [3:0] ACT_AUTH          = 4'd6;
	localparam logic [3:0] ACT_USER          = 4'd7;
	localparam logic [3:0] ACT_PASS          = 4'd8;
	localparam logic [3:0] ACT_MAIL          = 4'd9;
	localparam logic [3:0] ACT_RCPT          = 4'd10;
	localparam logic [3:0] ACT_DATA          = 4'd11;
	localparam logic [3:0] ACT_BODY          = 4'd12;
	localparam logic [3:0] ACT_QUIT          = 4'd13;
	localparam logic [3:0] ACT_DISCONNECT    = 4'd14;
	localparam logic [3:0] ACT_ABORT         = 4'd15;

	// Status codes.
	localparam logic [3:0] ST_NONE       = 4'd0;
	localparam logic [3:0] ST_BUSY       = 4'd1;
	localparam logic [3:0] ST_NO_RCPT    = 4'd2;
	localparam logic [3:0] ST_NO_HOST    = 4'd3;
	localparam logic [3:0] ST_UNEXPECTED = 4'd4;
	localparam logic [3:0] ST_AUTH_FAIL  = 4'd5;
	localparam logic [3:0] ST_RCPT_REJ   = 4'd6;
	localparam logic [3:0] ST_SOCK_ERR   = 4'd7;
	localparam logic [3:0] ST_TIMEOUT    = 4'd8;
	localparam logic [3:0] ST_SENT       = 4'd9;

	// Reply codes and defaults.
	localparam logic [9:0] CODE_READY     = 10'd220;
	localparam logic [9:0] CODE_OK        = 10'd250;
	localparam logic [9:0] CODE_FORWARD   = 10'd251;
	localparam logic [9:0] CODE_AUTH_CONT = 10'd334;
	localparam logic [9:0] CODE_AUTH_OK   = 10'd235;
	localparam logic [9:0] CODE_DATA_GO   = 10'd354;

	localparam logic [15:0] PORT_TLS        = 16'd465;
	localparam logic [15:0] PORT_PLAIN      = 16'd25;
	localparam logic [15:0] TIMEOUT_DEFAULT = 16'd30;

	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_DASH  = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// One classified input word as it travels through the queue.
	typedef struct packed {
		logic [2:0] kind;
		logic [4:0] cnt;
		logic       is_lf;
		logic       is_cr;
		logic       is_dash;
		logic       is_digit;
		logic [3:0] digit;
	} event_t;

	typedef struct packed {
		logic [1:0]  security_mode;
		logic        auth_enabled;
		logic        host_configured;
		logic [15:0] server_port;
		logic [15:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [9:0]  reply_code;
		logic [3:0]  status;
		logic [15:0] connect_port;
		logic [3:0]  rcpt_slot;
		logic [3:0]  action;
	} result_t;

endpackage

[design/smtpse_front.sv]
// ----------------------------------------------------------------------------
// SMTP session engine front
// Accepts input words, decodes the request kind, saturates the recipient
// count and classifies reply bytes for the line parser.
// ----------------------------------------------------------------------------
module smtpse_front import smtpse_pkg::*; #(
	parameter int MAX_RECIPIENTS = 16
) (
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // rcpt_count[4:0], rx_byte[12:5], zero pad
	input  logic [2:0]  s_tuser,   // req_type[2:0]
	input  logic        full,
	output logic        push,
	output event_t      push_event
);

	logic [4:0] cnt_in;
	logic [7:0] rx_byte;

	assign cnt_in  = s_tdata[4:0];
	assign rx_byte = s_tdata[12:5];

	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	always_comb begin
		push_event = '0;
		case (s_tuser)
			KIND_SEND, KIND_CONN, KIND_ENC, KIND_BYTE, KIND_TICK, KIND_SOCK_ERR: begin
				push_event.kind = s_tuser;
			end
			default: begin
				push_event.kind = KIND_NONE;
			end
		endcase
		if (int'(cnt_in) > MAX_RECIPIENTS) begin
			push_event.cnt = 5'(MAX_RECIPIENTS);
		end else begin
			push_event.cnt = cnt_in;
		end
		push_event.is_lf    = (rx_byte == CHAR_LF);
		push_event.is_cr    = (rx_byte == CHAR_CR);
		push_event.is_dash  = (rx_byte == CHAR_DASH);
		push_event.is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
		push_event.digit    = 4'(rx_byte - CHAR_ZERO);
	end

endmodule

[design/smtpse_queue.sv]
// ----------------------------------------------------------------------------
// SMTP session engine event queue
// Two-entry queue between the front classifier and the session sequencer.
// ----------------------------------------------------------------------------
module smtpse_queue import smtpse_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  event_t push_event,
	input  logic   pop,
	output logic   full,
	output logic   empty,
	output event_t head
);

	event_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_event;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("event queue written while full");

endmodule

[design/smtpse_back.sv]
// ----------------------------------------------------------------------------
// SMTP session engine sequencer
// Runs the reply line parser, the session phase machine and the timeout
// counter on one queued word per cycle, unless stalled, and registers its result.
// ----------------------------------------------------------------------------
module smtpse_back import smtpse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        empty,
	input  event_t      head,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // action[3:0], rcpt_slot[7:4], connect_port[23:8],
	                               // status[27:24], reply_code[37:28], zero pad
);

	localparam logic [3:0] PH_IDLE       = 4'd0;
	localparam logic [3:0] PH_CONNECTING = 4'd1;
	localparam logic [3:0] PH_GREETING   = 4'd2;
	localparam logic [3:0] PH_EHLO       = 4'd3;
	localparam logic [3:0] PH_STARTTLS   = 4'd4;
	localparam logic [3:0] PH_EHLO_TLS   = 4'd5;
	localparam logic [3:0] PH_AUTH_USER  = 4'd6;
	localparam logic [3:0] PH_AUTH_NAME  = 4'd7;
	localparam logic [3:0] PH_AUTH_PASS  = 4'd8;
	localparam logic [3:0] PH_MAIL       = 4'd9;
	localparam logic [3:0] PH_RCPT       = 4'd10;
	localparam logic [3:0] PH_DATA       = 4'd11;
	localparam logic [3:0] PH_BODY       = 4'd12;
	localparam logic [3:0] PH_QUIT       = 4'd13;
	localparam logic [3:0] PH_DONE       = 4'd14;
	localparam logic [3:0] PH_FAILED     = 4'd15;

	logic [3:0]  phase_q,        phase_d;
	logic        ehlo2_done_q,   ehlo2_done_d;
	logic [4:0]  rcpt_pos_q,     rcpt_pos_d;
	logic [4:0]  rcpt_total_q,   rcpt_total_d;
	logic [2:0]  line_len_q,     line_len_d;
	logic [9:0]  code_accum_q,   code_accum_d;
	logic        digits_valid_q, digits_valid_d;
	logic        fourth_dash_q,  fourth_dash_d;
	logic        last_cr_q,      last_cr_d;
	logic [15:0] elapsed_q,      elapsed_d;
	logic        out_valid_q;
	result_t     out_q;
	result_t     res;

	logic        active;
	logic        implicit_tls;
	logic [2:0]  eff_len;
	logic        take_line;
	logic [13:0] accum_wide;
	logic [4:0]  rcpt_next;
	logic [15:0] elapsed_inc;
	logic [15:0] limit;

	assign active = (phase_q != PH_IDLE) && (phase_q != PH_DONE) && (phase_q != PH_FAILED);
	assign implicit_tls = (cfg.security_mode == SEC_IMPLICIT);

	assign eff_len    = line_len_q - {2'b00, last_cr_q};
	assign take_line  = (eff_len >= 3'd3) && !((eff_len > 3'd3) && fourth_dash_q)
	                    && digits_valid_q;
	assign accum_wide = {4'b0000, code_accum_q} * 14'd10 + {10'd0, head.digit};
	assign rcpt_next  = rcpt_pos_q + 5'd1;
	assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
	assign limit      = (cfg.timeout_ticks != 16'd0) ? cfg.timeout_ticks : TIMEOUT_DEFAULT;

	assign pop = !empty && (!out_valid_q || m_tready);

	always_comb begin
		phase_d        = phase_q;
		ehlo2_done_d   = ehlo2_done_q;
		rcpt_pos_d     = rcpt_pos_q;
		rcpt_total_d   = rcpt_total_q;
		line_len_d     = line_len_q;
		code_accum_d   = code_accum_q;
		digits_valid_d = digits_valid_q;
		fourth_dash_d  = fourth_dash_q;
		last_cr_d      = last_cr_q;
		elapsed_d      = elapsed_q;
		res            = '0;

		case (head.kind)
			KIND_SEND: begin
				if (active) begin
					res.status = ST_BUSY;
				end else if (head.cnt == 5'd0) begin
					res.status = ST_NO_RCPT;
				end else if (!cfg.host_configured) begin
					res.status = ST_NO_HOST;
				end else begin
					rcpt_total_d   = head.cnt;
					rcpt_pos_d     = 5'd0;
					ehlo2_done_d   = 1'b0;
					line_len_d     = 3'd0;
					code_accum_d   = 10'd0;
					digits_valid_d = 1'b1;
					fourth_dash_d  = 1'b0;
					last_cr_d      = 1'b0;
					elapsed_d      = 16'd0;
					phase_d        = PH_CONNECTING;
					res.action     = implicit_tls ? ACT_CONNECT_TLS : ACT_CONNECT_PLAIN;
					if (cfg.server_port != 16'd0) begin
						res.connect_port = cfg.server_port;
					end else begin
						res.connect_port = implicit_tls ? PORT_TLS : PORT_PLAIN;
					end
				end
			end
			KIND_CONN: begin
				if (phase_q == PH_CONNECTING) begin
					phase_d = PH_GREETING;
				end
			end
			KIND_ENC: begin
				if (phase_q == PH_CONNECTING) begin
					phase_d = PH_GREETING;
				end else if (phase_q == PH_STARTTLS) begin
					ehlo2_done_d = 1'b1;
					res.action   = ACT_EHLO;
					phase_d      = PH_EHLO_TLS;
				end
			end
			KIND_BYTE: begin
				if (head.is_lf) begin
					line_len_d     = 3'd0;
					code_accum_d   = 10'd0;
					digits_valid_d = 1'b1;
					fourth_dash_d  = 1'b0;
					last_cr_d      = 1'b0;
					if (take_line) begin
						// Any mismatch aborts with the offending code.
						res.reply_code = code_accum_q;
						case (phase_q)
							PH_GREETING: begin
								if (code_accum_q != CODE_READY) begin
									res.action = ACT_ABORT;
									res.status = ST_UNEXPECTED;
									phase_d    = PH_FAILED;
								end else begin
									res.reply_code = 10'd0;
									res.action     = ACT_EHLO;
									phase_d        = PH_EHLO;
								end
							end
							PH_EHLO, PH_EHLO_TLS: begin
								if (code_accum_q != CODE_OK) begin
									res.action = ACT_ABORT;
									res.status = ST_UNEXPECTED;
									phase_d    = PH_FAILED;
								end else begin
									res.reply_code = 10'd0;
									if (phase_q == PH_EHLO && cfg.security_mode == SEC_STARTTLS
									    && !ehlo2_done_q) begin
										res.action = ACT_STARTTLS;
										phase_d    = PH_STARTTLS;
									end else if (cfg.auth_enabled) begin
										res.action = ACT_AUTH;
										phase_d    = PH_AUTH_USER;
									end else begin
										res.action = ACT_MAIL;
										phase_d    = PH_MAIL;
									end
								end
							end
							PH_STARTTLS: begin
								if (code_accum_q != CODE_READY) begin
									res.action = ACT_ABORT;
									res.status = ST_UNEXPECTED;
									phase_d    = PH_FAILED;
								end else begin
									res.reply_code = 10'd0;
									res.action     = ACT_START_TLS;
								end
							end
							PH_AUTH_USER, PH_AUTH_NAME: begin
								if (code_accum_q != CODE_AUTH_CONT) begin
									res.action = ACT_ABORT;
									res.status = ST_UNEXPECTED;
									phase_d    = PH_FAILED;
								end else begin
									res.reply_code = 10'd0;
									res.action = (phase_q == PH_AUTH_USER) ? ACT_USER : ACT_PASS;
									phase_d = (phase_q == PH_AUTH_USER) ? PH_AUTH_NAME
									                                    : PH_AUTH_PASS;
								end
							end
							PH_AUTH_PASS: begin
								if (code_accum_q != CODE_AUTH_OK) begin
									res.action = ACT_ABORT;
									res.status = ST_AUTH_FAIL;
									phase_d    = PH_FAILED;
								end else begin
									res.reply_code = 10'd0;
									res.action     = ACT_MAIL;
									phase_d        = PH_MAIL;
								end
							end
							PH_MAIL: begin
								if (code_accum_q != CODE_OK) begin
									res.action = ACT_ABORT;
									res.status = ST_UNEXPECTED;
									phase_d    = PH_FAILED;
								end else begin
									res.reply_code = 10'd0;
									res.action     = ACT_RCPT;
									res.rcpt_slot  = rcpt_pos_q[3:0];
									phase_d        = PH_RCPT;
								end
							end
							PH_RCPT: begin
								if (code_accum_q != CODE_OK && code_accum_q != CODE_FORWARD) begin
									res.action = ACT_ABORT;
									res.status = ST_RCPT_REJ;
									phase_d    = PH_FAILED;
								end else begin
									res.reply_code = 10'd0;
									rcpt_pos_d     = rcpt_next;
									if (rcpt_next < rcpt_total_q) begin
										res.action    = ACT_RCPT;
										res.rcpt_slot = rcpt_next[3:0];
									end else begin
										res.action = ACT_DATA;
										phase_d    = PH_DATA;
									end
								end
							end
							PH_DATA: begin
								if (code_accum_q != CODE_DATA_GO) begin
									res.action = ACT_ABORT;
									res.status = ST_UNEXPECTED;
									phase_d    = PH_FAILED;
								end else begin
									res.reply_code = 10'd0;
									res.action     = ACT_BODY;
									phase_d        = PH_BODY;
								end
							end
							PH_BODY: begin
								if (code_accum_q != CODE_OK) begin
									res.action = ACT_ABORT;
									res.status = ST_UNEXPECTED;
									phase_d    = PH_FAILED;
								end else begin
									res.reply_code = 10'd0;
									res.action     = ACT_QUIT;
									phase_d        = PH_QUIT;
								end
							end
							PH_QUIT: begin
								// Whatever the server answers to QUIT ends the session.
								res.reply_code = 10'd0;
								res.action     = ACT_DISCONNECT;
								res.status     = ST_SENT;
								phase_d        = PH_DONE;
							end
							default: begin
								res.reply_code = 10'd0;
							end
						endcase
					end
				end else begin
					if (line_len_q < 3'd3) begin
						if (head.is_digit) begin
							code_accum_d = accum_wide[9:0];
						end else begin
							digits_valid_d = 1'b0;
						end
					end else if (line_len_q == 3'd3) begin
						fourth_dash_d = head.is_dash;
					end
					if (line_len_q != 3'd7) begin
						line_len_d = line_len_q + 3'd1;
					end
					last_cr_d = head.is_cr;
				end
			end
			KIND_TICK: begin
				if (active) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc >= limit) begin
						res.action = ACT_ABORT;
						res.status = ST_TIMEOUT;
						phase_d    = PH_FAILED;
					end
				end
			end
			KIND_SOCK_ERR: begin
				if (active) begin
					res.action = ACT_ABORT;
					res.status = ST_SOCK_ERR;
					phase_d    = PH_FAILED;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			ehlo2_done_q   <= 1'b0;
			rcpt_pos_q     <= 5'd0;
			rcpt_total_q   <= 5'd0;
			line_len_q     <= 3'd0;
			code_accum_q   <= 10'd0;
			digits_valid_q <= 1'b1;
			fourth_dash_q  <= 1'b0;
			last_cr_q      <= 1'b0;
			elapsed_q      <= 16'd0;
			out_valid_q    <= 1'b0;
		end else begin
			if (pop) begin
				phase_q        <= phase_d;
				ehlo2_done_q   <= ehlo2_done_d;
				rcpt_pos_q     <= rcpt_pos_d;
				rcpt_total_q   <= rcpt_total_d;
				line_len_q     <= line_len_d;
				code_accum_q   <= code_accum_d;
				digits_valid_q <= digits_valid_d;
				fourth_dash_q  <= fourth_dash_d;
				last_cr_q      <= last_cr_d;
				elapsed_q      <= elapsed_d;
				out_valid_q    <= 1'b1;
			end else if (m_tready) begin
				out_valid_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q};

	a_timeout_fails: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == ST_TIMEOUT) |-> (phase_q == PH_FAILED))
		else $error("timeout reported but session not failed");

	a_sent_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == ST_SENT) |-> (phase_q == PH_DONE))
		else $error("sent reported but session not done");

	a_rcpt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RCPT) |-> (rcpt_pos_q < rcpt_total_q))
		else $error("recipient position past recipient total");

endmodule

[design/smtp_client_session_engine.sv]
// ----------------------------------------------------------------------------
// SMTP client session engine
// Sequences an SMTP client session from requests, socket events and reply
// bytes, and names the next command for software to send.
// ----------------------------------------------------------------------------
// One input word is taken per cycle while the queue is not full, and gives
// exactly one result word, in order. Each word passes a classifier, a two-entry
// queue and the session sequencer, which takes one word per clock while results
// are taken; a word waits in its queue entry and its result is registered, and
// stays on the master side until taken. Reply bytes are gathered into lines;
// only final reply lines with a three-digit code move the session on. The
// configuration registers are written through the cfg channel, which is always
// ready, and should only be changed while no session word is in flight.
module smtp_client_session_engine import smtpse_pkg::*; #(
	parameter int MAX_RECIPIENTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // rcpt_count[4:0], rx_byte[12:5], zero pad
	input  logic [2:0]  s_tuser,   // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // action[3:0], rcpt_slot[7:4], connect_port[23:8],
	                               // status[27:24], reply_code[37:28], zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t   cfg_q;
	logic   push;
	logic   pop;
	logic   full;
	logic   empty;
	event_t push_event;
	event_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SECURITY_MODE: cfg_q.security_mode   <= cfg_data[1:0];
				CFG_AUTH_ENABLED:  cfg_q.auth_enabled    <= cfg_data[0];
				CFG_HOST:          cfg_q.host_configured <= cfg_data[0];
				CFG_SERVER_PORT:   cfg_q.server_port     <= cfg_data;
				CFG_TIMEOUT:       cfg_q.timeout_ticks   <= cfg_data;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	smtpse_front #(
		.MAX_RECIPIENTS(MAX_RECIPIENTS)
	) u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.full      (full),
		.push      (push),
		.push_event(push_event)
	);

	smtpse_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_event(push_event),
		.pop       (pop),
		.full      (full),
		.empty     (empty),
		.head      (head)
	);

	smtpse_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.empty   (empty),
		.head    (head),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

[tb/sv/tb_smtp_client_session_engine.sv]
// ----------------------------------------------------------------------------
// SMTP client session engine testbench
// Drives requests, socket events and server reply lines into the engine and
// compares every result word with a cycle-free model of the session sequencer.
// Most stimulus is complete sessions whose replies follow the model's current
// phase, mixed with wrong codes, skipped lines, timeouts and socket errors.
// ----------------------------------------------------------------------------
module tb_smtp_client_session_engine;
	import smtpse_pkg::*;

	localparam int MAX_RCPT    = 16;
	localparam int ITEM_TARGET = 1720;
	localparam int LONG_HOLD   = 300;

	localparam logic [1:0] SEC_PLAIN = 2'd0;
	localparam logic [1:0] SEC_ODD   = 2'd3;

	typedef enum logic [3:0] {
		PH_IDLE, PH_CONNECTING, PH_GREETING, PH_EHLO, PH_STARTTLS, PH_EHLO_TLS,
		PH_AUTH_USER, PH_AUTH_NAME, PH_AUTH_PASS, PH_MAIL, PH_RCPT, PH_DATA,
		PH_BODY, PH_QUIT, PH_DONE, PH_FAILED
	} sess_phase_e;

	typedef enum int {LN_FINAL, LN_CONT, LN_BAD, LN_SHORT} line_kind_e;

	class session_scoreboard;
		cfg_t        regs;
		sess_phase_e ph;
		logic        tls_ehlo_seen;
		logic [4:0]  rcpt_idx;
		logic [4:0]  rcpt_num;
		logic [2:0]  line_len;
		logic [9:0]  code_acc;
		logic        digits_ok;
		logic [7:0]  sep_char;
		logic        prev_cr;
		logic [15:0] ticks;
		result_t     res;
		result_t     expected_q[$];
		int          errors;

		function new();
			regs = '0;
			ph = PH_IDLE;
			tls_ehlo_seen = 1'b0;
			rcpt_idx = '0;
			rcpt_num = '0;
			clear_line();
			ticks = '0;
			errors = 0;
		endfunction

		function void clear_line();
			line_len = '0;
			code_acc = '0;
			digits_ok = 1'b1;
			sep_char = '0;
			prev_cr = 1'b0;
		endfunction

		function bit active();
			return ph != PH_IDLE && ph != PH_DONE && ph != PH_FAILED;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] data);
			case (idx)
				CFG_SECURITY_MODE: regs.security_mode = data[1:0];
				CFG_AUTH_ENABLED:  regs.auth_enabled = data[0];
				CFG_HOST:          regs.host_configured = data[0];
				CFG_SERVER_PORT:   regs.server_port = data;
				CFG_TIMEOUT:       regs.timeout_ticks = data;
				default: ;
			endcase
		endfunction

		function void abort_session(logic [3:0] st, logic [9:0] code);
			ph = PH_FAILED;
			res.action = ACT_ABORT;
			res.status = st;
			res.reply_code = code;
		endfunction

		function void auth_or_mail();
			if (regs.auth_enabled) begin
				res.action = ACT_AUTH;
				ph = PH_AUTH_USER;
			end else begin
				res.action = ACT_MAIL;
				ph = PH_MAIL;
			end
		endfunction

		// A final reply line with a valid three-digit code moves the session on.
		function void on_code(logic [9:0] code);
			case (ph)
				PH_GREETING: begin
					if (code != CODE_READY) abort_session(ST_UNEXPECTED, code);
					else begin
						res.action = ACT_EHLO;
						ph = PH_EHLO;
					end
				end
				PH_EHLO: begin
					if (code != CODE_OK) abort_session(ST_UNEXPECTED, code);
					else if (regs.security_mode == SEC_STARTTLS && !tls_ehlo_seen) begin
						res.action = ACT_STARTTLS;
						ph = PH_STARTTLS;
					end else auth_or_mail();
				end
				PH_STARTTLS: begin
					if (code != CODE_READY) abort_session(ST_UNEXPECTED, code);
					else res.action = ACT_START_TLS;
				end
				PH_EHLO_TLS: begin
					if (code != CODE_OK) abort_session(ST_UNEXPECTED, code);
					else auth_or_mail();
				end
				PH_AUTH_USER: begin
					if (code != CODE_AUTH_CONT) abort_session(ST_UNEXPECTED, code);
					else begin
						res.action = ACT_USER;
						ph = PH_AUTH_NAME;
					end
				end
				PH_AUTH_NAME: begin
					if (code != CODE_AUTH_CONT) abort_session(ST_UNEXPECTED, code);
					else begin
						res.action = ACT_PASS;
						ph = PH_AUTH_PASS;
					end
				end
				PH_AUTH_PASS: begin
					if (code != CODE_AUTH_OK) abort_session(ST_AUTH_FAIL, code);
					else begin
						res.action = ACT_MAIL;
						ph = PH_MAIL;
					end
				end
				PH_MAIL: begin
					if (code != CODE_OK) abort_session(ST_UNEXPECTED, code);
					else begin
						res.action = ACT_RCPT;
						res.rcpt_slot = rcpt_idx[3:0];
						ph = PH_RCPT;
					end
				end
				PH_RCPT: begin
					if (code != CODE_OK && code != CODE_FORWARD) abort_session(ST_RCPT_REJ, code);
					else begin
						rcpt_idx++;
						if (rcpt_idx < rcpt_num) begin
							res.action = ACT_RCPT;
							res.rcpt_slot = rcpt_idx[3:0];
						end else begin
							res.action = ACT_DATA;
							ph = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					if (code != CODE_DATA_GO) abort_session(ST_UNEXPECTED, code);
					else begin
						res.action = ACT_BODY;
						ph = PH_BODY;
					end
				end
				PH_BODY: begin
					if (code != CODE_OK) abort_session(ST_UNEXPECTED, code);
					else begin
						res.action = ACT_QUIT;
						ph = PH_QUIT;
					end
				end
				PH_QUIT: begin
					ph = PH_DONE;
					res.action = ACT_DISCONNECT;
					res.status = ST_SENT;
				end
				default: ;
			endcase
		endfunction

		function void on_rx(logic [7:0] b);
			int         eff;
			logic [7:0] sep;
			bit         take;
			logic [9:0] code;
			if (b == CHAR_LF) begin
				eff = int'(line_len) - (prev_cr ? 1 : 0);
				sep = (eff > 3) ? sep_char : 8'h20;
				take = eff >= 3 && sep != CHAR_DASH && digits_ok;
				code = code_acc;
				clear_line();
				if (take) on_code(code);
			end else begin
				if (line_len < 3) begin
					if (b >= CHAR_ZERO && b <= CHAR_NINE)
						code_acc = 10'(code_acc * 10 + (b - CHAR_ZERO));
					else
						digits_ok = 1'b0;
				end else if (line_len == 3) begin
					sep_char = b;
				end
				if (line_len < 7) line_len++;
				prev_cr = (b == CHAR_CR);
			end
		endfunction

		function void note_input(logic [2:0] kind, logic [4:0] cnt, logic [7:0] rx);
			logic [15:0] lim;
			res = '0;
			case (kind)
				KIND_SEND: begin
					if (active()) res.status = ST_BUSY;
					else if (cnt == 0) res.status = ST_NO_RCPT;
					else if (!regs.host_configured) res.status = ST_NO_HOST;
					else begin
						rcpt_num = (cnt > MAX_RCPT) ? 5'(MAX_RCPT) : cnt;
						rcpt_idx = '0;
						tls_ehlo_seen = 1'b0;
						clear_line();
						ticks = '0;
						ph = PH_CONNECTING;
						res.action = (regs.security_mode == SEC_IMPLICIT) ?
							ACT_CONNECT_TLS : ACT_CONNECT_PLAIN;
						if (regs.server_port != 0) res.connect_port = regs.server_port;
						else if (regs.security_mode == SEC_IMPLICIT) res.connect_port = PORT_TLS;
						else res.connect_port = PORT_PLAIN;
					end
				end
				KIND_CONN: begin
					if (ph == PH_CONNECTING) ph = PH_GREETING;
				end
				KIND_ENC: begin
					if (ph == PH_CONNECTING) ph = PH_GREETING;
					else if (ph == PH_STARTTLS) begin
						tls_ehlo_seen = 1'b1;
						res.action = ACT_EHLO;
						ph = PH_EHLO_TLS;
					end
				end
				KIND_BYTE: on_rx(rx);
				KIND_TICK: begin
					if (active()) begin
						lim = (regs.timeout_ticks != 0) ? regs.timeout_ticks : TIMEOUT_DEFAULT;
						if (ticks != 16'hFFFF) ticks++;
						if (ticks >= lim) abort_session(ST_TIMEOUT, '0);
					end
				end
				KIND_SOCK_ERR: begin
					if (active()) abort_session(ST_SOCK_ERR, '0);
				end
				default: ;
			endcase
			expected_q.push_back(res);
		endfunction

		function void mismatch(string field, int want, int got);
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
			errors++;
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result word: expected none, actual action %0d status %0d",
					$time, got.action, got.status);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.action != want.action) mismatch("action", want.action, got.action);
			if (got.rcpt_slot != want.rcpt_slot) mismatch("rcpt_slot", want.rcpt_slot, got.rcpt_slot);
			if (got.connect_port != want.connect_port)
				mismatch("connect_port", want.connect_port, got.connect_port);
			if (got.status != want.status) mismatch("status", want.status, got.status);
			if (got.reply_code != want.reply_code)
				mismatch("reply_code", want.reply_code, got.reply_code);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	session_scoreboard sb;
	int                items_sent;
	bit                quiet;
	bit                long_hold_req;

	smtp_client_session_engine #(
		.MAX_RECIPIENTS(MAX_RCPT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

	// Mostly back to back, sometimes a short gap, rarely a long one.
	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] any_char();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		return (b == CHAR_LF) ? CHAR_CR : b;
	endfunction

	function automatic logic [4:0] pick_count();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 5'd0;
		if (r == 1) return 5'($urandom_range(MAX_RCPT + 1, 31));
		if (r == 2) return 5'(MAX_RCPT);
		return 5'($urandom_range(1, 4));
	endfunction

	function automatic logic [9:0] wanted_code(sess_phase_e p);
		case (p)
			PH_GREETING, PH_STARTTLS: return CODE_READY;
			PH_EHLO, PH_EHLO_TLS, PH_MAIL, PH_BODY: return CODE_OK;
			PH_AUTH_USER, PH_AUTH_NAME: return CODE_AUTH_CONT;
			PH_AUTH_PASS: return CODE_AUTH_OK;
			PH_RCPT: return $urandom_range(0, 1) ? CODE_OK : CODE_FORWARD;
			PH_DATA: return CODE_DATA_GO;
			default: return 10'($urandom_range(0, 999));
		endcase
	endfunction

	// The valid stays high from one word to the next unless a gap is taken.
	task automatic push_word(input logic [2:0] kind, input logic [4:0] cnt, input logic [7:0] rx);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {3'b000, rx, cnt};
		do @(posedge clk); while (!s_tready);
		sb.note_input(kind, cnt, rx);
		items_sent++;
	endtask

	task automatic push_event(input logic [2:0] kind);
		push_word(kind, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
	endtask

	task automatic push_send(input logic [4:0] cnt);
		push_word(KIND_SEND, cnt, 8'($urandom_range(0, 255)));
	endtask

	task automatic push_rx(input logic [7:0] b);
		push_word(KIND_BYTE, 5'($urandom_range(0, 31)), b);
	endtask

	task automatic send_line(input logic [9:0] code, input line_kind_e how);
		logic [7:0] txt[$];
		logic [7:0] b;
		int         n;
		int         pos;
		if (how == LN_SHORT) begin
			n = $urandom_range(0, 2);
			repeat (n) txt.push_back(any_char());
		end else begin
			txt.push_back(8'(CHAR_ZERO + code / 100));
			txt.push_back(8'(CHAR_ZERO + (code / 10) % 10));
			txt.push_back(8'(CHAR_ZERO + code % 10));
			if (how == LN_BAD) begin
				pos = $urandom_range(0, 2);
				b = 8'($urandom_range(0, 255));
				if ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_LF) b = b ^ 8'h40;
				txt[pos] = b;
			end
			if (how == LN_CONT) txt.push_back(CHAR_DASH);
			else begin
				case ($urandom_range(0, 3))
					0, 1: txt.push_back(8'h20);
					2: ;
					default: txt.push_back(any_char());
				endcase
			end
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
			repeat (n) txt.push_back(any_char());
		end
		if ($urandom_range(0, 3) != 0) txt.push_back(CHAR_CR);
		txt.push_back(CHAR_LF);
		foreach (txt[i]) push_rx(txt[i]);
	endtask

	// Wait until every result has been taken; no word is in flight afterwards.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic configure(input logic [1:0] mode, input logic auth, input logic host,
	                         input logic [15:0] port, input logic [15:0] tmo);
		write_reg(CFG_SECURITY_MODE, {14'd0, mode});
		write_reg(CFG_AUTH_ENABLED, {15'd0, auth});
		write_reg(CFG_HOST, {15'd0, host});
		write_reg(CFG_SERVER_PORT, port);
		write_reg(CFG_TIMEOUT, tmo);
		cfg_valid <= 1'b0;
	endtask

	// Walks one session to its end, answering each phase mostly as a server
	// would, with wrong codes, skipped lines and stray events mixed in.
	task automatic run_session();
		int         guard;
		int         r;
		bit         tls_asked;
		logic [9:0] code;
		guard = 0;
		tls_asked = 1'b0;
		if (!sb.active()) push_send(pick_count());
		while (sb.active() && guard < 300) begin
			guard++;
			r = $urandom_range(0, 199);
			if (r < 3) push_event(KIND_TICK);
			else if (r < 4) push_event(KIND_SOCK_ERR);
			else if (r < 6) push_send(pick_count());
			else if (r < 9) push_event($urandom_range(0, 1) ? KIND_CONN : KIND_ENC);
			else if (r < 11) push_event(3'($urandom_range(KIND_NONE, 7)));
			else if (r < 24)
				send_line(wanted_code(sb.ph), line_kind_e'($urandom_range(LN_CONT, LN_SHORT)));
			else if (sb.ph == PH_CONNECTING) begin
				if (sb.regs.security_mode == SEC_IMPLICIT || $urandom_range(0, 1))
					push_event(KIND_ENC);
				else
					push_event(KIND_CONN);
			end else if (sb.ph == PH_STARTTLS && tls_asked && $urandom_range(0, 3) != 0) begin
				push_event(KIND_ENC);
				tls_asked = 1'b0;
			end else begin
				code = ($urandom_range(0, 24) == 0) ? 10'($urandom_range(0, 999)) :
					wanted_code(sb.ph);
				if (sb.ph == PH_STARTTLS) tls_asked = 1'b1;
				send_line(code, LN_FINAL);
			end
		end
	endtask

	initial begin
		int         hold;
		hold = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) sb.check_result(result_t'(m_tdata[37:0]));
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD;
				m_tready <= 1'b0;
			end else begin
				hold = pick_gap();
				m_tready <= (hold == 0);
				if (hold > 0) hold--;
			end
		end
	end

	initial begin
		int         epoch;
		int         n;
		logic [15:0] port;
		logic [15:0] tmo;
		sb = new();
		items_sent = 0;
		quiet = 1'b0;
		long_hold_req = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= KIND_NONE;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_SECURITY_MODE;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Registers at reset: no host, so every send is refused.
		push_send(5'd0);
		push_send(5'd31);
		push_event(KIND_CONN);
		push_event(KIND_ENC);
		push_event(KIND_TICK);
		push_event(KIND_SOCK_ERR);
		push_event(KIND_NONE);
		push_event(3'd7);
		push_rx(8'hFF);
		push_rx(8'h00);
		push_rx(CHAR_LF);
		settle();

		// Implicit TLS on the default port, saturated recipients, one-tick timeout.
		configure(SEC_IMPLICIT, 1'b1, 1'b1, 16'd0, 16'd1);
		push_send(5'd31);
		push_send(5'd1);
		push_event(KIND_TICK);
		push_event(KIND_SOCK_ERR);
		settle();

		// The unused security mode behaves as plaintext.
		configure(SEC_ODD, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF);
		push_send(5'd1);
		push_event(KIND_ENC);
		push_event(KIND_SOCK_ERR);

		epoch = 0;
		while (items_sent < ITEM_TARGET) begin
			settle();
			case (epoch)
				0: configure(SEC_STARTTLS, 1'b1, 1'b1, 16'd0, 16'd0);
				1: configure(SEC_PLAIN, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF);
				2: configure(SEC_IMPLICIT, 1'b1, 1'b1, 16'd0, 16'd0);
				default: begin
					case ($urandom_range(0, 3))
						0: port = 16'd0;
						1: port = 16'hFFFF;
						2: port = PORT_PLAIN;
						default: port = 16'($urandom_range(0, 65535));
					endcase
					case ($urandom_range(0, 5))
						0: tmo = 16'd0;
						1: tmo = 16'hFFFF;
						2: tmo = 16'($urandom_range(1, 3));
						default: tmo = 16'($urandom_range(20, 400));
					endcase
					configure(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
						$urandom_range(0, 9) != 0, port, tmo);
				end
			endcase
			quiet = (epoch % 5 == 3);
			// Stall the output long enough for the block to back up its input.
			if (epoch == 0) long_hold_req = 1'b1;
			n = $urandom_range(3, 8);
			repeat (n) begin
				if (items_sent >= ITEM_TARGET) break;
				run_session();
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 3)) push_event(3'($urandom_range(0, 7)));
				end
				if ($urandom_range(0, 9) == 0) settle();
			end
			if (sb.active()) push_event(KIND_SOCK_ERR);
			epoch++;
		end

		settle();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[files.f]
design/smtpse_pkg.sv
design/smtpse_front.sv
design/smtpse_queue.sv
design/smtpse_back.sv
design/smtp_client_session_engine.sv
tb/sv/tb_smtp_client_session_engine.sv
